// File: src/cbbox_pkg.sv
// Package for the color blob bounding box unit.
// Holds transaction types, register and code constants and the color rules.
// No dependencies.
package cbbox_pkg;

   localparam int DIM_W   = 13;
   localparam int DIM_MAX = 2 ** DIM_W - 1;
   localparam int COUNT_W = 25;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam int PROD_W  = 2 * DIM_W;
   localparam int CMP_W   = 32;
   localparam int NUM_COLORS = 3;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MIN_AREA     = 2'd2;

   localparam logic [DIM_W-1:0]   RESET_IMAGE_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0]   RESET_IMAGE_HEIGHT = 13'd480;
   localparam logic [COUNT_W-1:0] RESET_MIN_AREA     = 25'd40;

   localparam logic [1:0] COLOR_RED    = 2'd0;
   localparam logic [1:0] COLOR_YELLOW = 2'd1;
   localparam logic [1:0] COLOR_BLUE   = 2'd2;

   localparam logic [1:0] SHAPE_UNKNOWN = 2'd0;
   localparam logic [1:0] SHAPE_BALL    = 2'd1;
   localparam logic [1:0] SHAPE_CUBE    = 2'd2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [1:0]         color_id;
      logic [12:0]        left;
      logic [11:0]        right;
      logic [12:0]        top;
      logic [11:0]        bottom;
      logic [COUNT_W-1:0] area;
      logic               found;
      logic [1:0]         shape;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]   left;
      logic [DIM_W-1:0]   right;
      logic [DIM_W-1:0]   top;
      logic [DIM_W-1:0]   bottom;
      logic [COUNT_W-1:0] count;
   } stats_type;

   function automatic logic color_match(logic [1:0] color, req_type px);
      logic [9:0] r;
      logic [9:0] g;
      logic [9:0] b;
      logic [9:0] d;
      logic       res;
      r = {2'b00, px.red};
      g = {2'b00, px.green};
      b = {2'b00, px.blue};
      d = (r > g) ? (r - g) : (g - r);
      case (color)
         COLOR_RED: begin
            res = (r > g + 10'd50) && (r > b + 10'd50) && (r > 10'd120)
                  && (g < 10'd80) && (b < 10'd80);
         end
         COLOR_YELLOW: begin
            res = (d < 10'd30) && (r > b + 10'd40) && (g > b + 10'd40)
                  && (r > 10'd120) && (g > 10'd120);
         end
         COLOR_BLUE: begin
            res = (b > r + 10'd40) && (b > g + 10'd40) && (b > 10'd120)
                  && (r < 10'd100) && (g < 10'd100);
         end
         default: begin
            res = 1'b0;
         end
      endcase
      return res;
   endfunction

endpackage

// File: src/cbbox_tracker.sv
// Bounding box and pixel count of one color over the current frame.
// Depends on cbbox_pkg.
module cbbox_tracker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      hit,
   input  logic                      frame_end,
   input  logic [cbbox_pkg::DIM_W-1:0] column,
   input  logic [cbbox_pkg::DIM_W-1:0] row,
   output cbbox_pkg::stats_type      updated
);
   import cbbox_pkg::*;

   stats_type stats_ff;
   stats_type stats_in;

   always_comb begin
      updated = stats_ff;
      if (accept && hit) begin
         if (stats_ff.count == '0) begin
            updated.left   = column;
            updated.right  = column;
            updated.top    = row;
            updated.bottom = row;
         end else begin
            if (column < stats_ff.left)  updated.left   = column;
            if (column > stats_ff.right) updated.right  = column;
            if (row < stats_ff.top)      updated.top    = row;
            if (row > stats_ff.bottom)   updated.bottom = row;
         end
         if (stats_ff.count != COUNT_MAX) updated.count = stats_ff.count + 1'b1;
      end
      stats_in = updated;
      if (accept && frame_end) stats_in.count = '0;
   end

   always_ff @(posedge clock) begin
      stats_ff.left   <= stats_in.left;
      stats_ff.right  <= stats_in.right;
      stats_ff.top    <= stats_in.top;
      stats_ff.bottom <= stats_in.bottom;
      if (reset) begin
         stats_ff.count <= '0;
      end else begin
         stats_ff.count <= stats_in.count;
      end
   end

endmodule

// File: src/color_blob_bounding_box_unit.sv
// Top level of the color blob bounding box unit.
// Depends on cbbox_pkg and cbbox_tracker.
//
// Pixels arrive in raster order on the req_ channel, one per transaction.
// Each pixel is tested against the red, yellow and blue rules and the
// matching colors' boxes and counts are updated in the cycle it is taken.
// A pixel is taken every cycle; the only exception is a frame's last pixel
// while the previous frame's three results are still pending.
// The last pixel of a frame freezes the statistics into a result buffer and
// clears them. Box areas are then multiplied into a product register, and
// each result is registered from both. The three results (red, yellow,
// blue; last set on blue) then leave one per cycle on rsp_ while rsp_ready
// is high. A stalled rsp_ready holds the current result; pixels of the
// next frame keep flowing. Registers are written over the csr_ APB port:
// width at 0x0, height at 0x4, min area at 0x8. Reset restores 640x480,
// min area 40, empties the statistics and drops any pending results.
module color_blob_bounding_box_unit #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cbbox_pkg::req_type              req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cbbox_pkg::rsp_type              rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cbbox_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cbbox_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cbbox_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import cbbox_pkg::*;

   localparam logic [DIM_W-1:0] W_CAP =
      (MAX_WIDTH > DIM_MAX) ? DIM_W'(DIM_MAX) : DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] H_CAP =
      (MAX_HEIGHT > DIM_MAX) ? DIM_W'(DIM_MAX) : DIM_W'(MAX_HEIGHT);

   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [COUNT_W-1:0] min_area_ff, min_area_in;
   logic               csr_write;
   logic [1:0]         csr_index;

   logic [DIM_W-1:0] w_eff, h_eff;
   logic [DIM_W-1:0] column_ff, column_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic             row_end, frame_end, req_accept, frame_accept;

   stats_type        updated [NUM_COLORS];
   stats_type        snap_ff [NUM_COLORS];
   logic [PROD_W-1:0] prod_ff [NUM_COLORS];
   logic             snap_full_ff, snap_full_in;
   logic             prod_ok_ff, prod_ok_in;
   logic [1:0]       idx_ff, idx_in;
   logic             load, last_load;

   stats_type         sel_stats;
   logic [PROD_W-1:0] sel_prod;
   logic [CMP_W-1:0]  area_x20, box_x17;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      min_area_in = min_area_ff;
      if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in    = csr_pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: height_in   = csr_pwdata[DIM_W-1:0];
            REG_MIN_AREA:     min_area_in = csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
      case (csr_index)
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         REG_MIN_AREA:     csr_prdata = CSR_DATA_W'(min_area_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RESET_IMAGE_WIDTH;
         height_ff   <= RESET_IMAGE_HEIGHT;
         min_area_ff <= RESET_MIN_AREA;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         min_area_ff <= min_area_in;
      end
   end

   // position
   always_comb begin
      w_eff = (width_ff == '0) ? DIM_W'(1) : ((width_ff > W_CAP) ? W_CAP : width_ff);
      h_eff = (height_ff == '0) ? DIM_W'(1) : ((height_ff > H_CAP) ? H_CAP : height_ff);
      row_end   = ({1'b0, column_ff} + 1'b1) >= {1'b0, w_eff};
      frame_end = row_end && (({1'b0, row_ff} + 1'b1) >= {1'b0, h_eff});
      req_ready    = !(snap_full_ff && frame_end);
      req_accept   = req_valid && req_ready;
      frame_accept = req_accept && frame_end;
      column_in = column_ff;
      row_in    = row_ff;
      if (req_accept) begin
         if (frame_end) begin
            column_in = '0;
            row_in    = '0;
         end else if (row_end) begin
            column_in = '0;
            row_in    = row_ff + 1'b1;
         end else begin
            column_in = column_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   for (genvar c = 0; c < NUM_COLORS; c++) begin : g_color
      cbbox_tracker u_tracker (
         .clock     (clock),
         .reset     (reset),
         .accept    (req_accept),
         .hit       (color_match(2'(c), req_data)),
         .frame_end (frame_end),
         .column    (column_ff),
         .row       (row_ff),
         .updated   (updated[c])
      );

      always_ff @(posedge clock) begin
         if (frame_accept) snap_ff[c] <= updated[c];
         prod_ff[c] <= (snap_ff[c].right - snap_ff[c].left + 1'b1)
                     * (snap_ff[c].bottom - snap_ff[c].top + 1'b1);
      end
   end

   // result sequencing
   assign load      = prod_ok_ff && (!rsp_valid_ff || rsp_ready);
   assign last_load = load && (idx_ff == COLOR_BLUE);

   always_comb begin
      snap_full_in = frame_accept ? 1'b1 : (last_load ? 1'b0 : snap_full_ff);
      prod_ok_in   = snap_full_ff && !last_load;
      idx_in       = last_load ? COLOR_RED : (load ? idx_ff + 1'b1 : idx_ff);
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_full_ff <= 1'b0;
         prod_ok_ff   <= 1'b0;
         idx_ff       <= COLOR_RED;
         rsp_valid_ff <= 1'b0;
      end else begin
         snap_full_ff <= snap_full_in;
         prod_ok_ff   <= prod_ok_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      case (idx_ff)
         COLOR_RED: begin
            sel_stats = snap_ff[0];
            sel_prod  = prod_ff[0];
         end
         COLOR_YELLOW: begin
            sel_stats = snap_ff[1];
            sel_prod  = prod_ff[1];
         end
         default: begin
            sel_stats = snap_ff[2];
            sel_prod  = prod_ff[2];
         end
      endcase
      area_x20 = CMP_W'({sel_stats.count, 4'b0000}) + CMP_W'({sel_stats.count, 2'b00});
      box_x17  = CMP_W'({sel_prod, 4'b0000}) + CMP_W'(sel_prod);
      rsp_in.color_id = idx_ff;
      rsp_in.area     = sel_stats.count;
      rsp_in.found    = sel_stats.count > min_area_ff;
      rsp_in.last     = (idx_ff == COLOR_BLUE);
      if (sel_stats.count == '0) begin
         rsp_in.left   = w_eff;
         rsp_in.right  = '0;
         rsp_in.top    = h_eff;
         rsp_in.bottom = '0;
         rsp_in.shape  = SHAPE_UNKNOWN;
      end else begin
         rsp_in.left   = sel_stats.left;
         rsp_in.right  = sel_stats.right[11:0];
         rsp_in.top    = sel_stats.top;
         rsp_in.bottom = sel_stats.bottom[11:0];
         rsp_in.shape  = (area_x20 > box_x17) ? SHAPE_CUBE : SHAPE_BALL;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/cbbox_checker.sv
// Port-level checks for the color blob bounding box unit, bound to the top.
// Depends on cbbox_pkg.
module cbbox_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input cbbox_pkg::rsp_type rsp_data
);
   import cbbox_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_last_blue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.color_id == COLOR_BLUE)))
      else $error("last flag not on blue result");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.area == '0 |->
         rsp_data.shape == SHAPE_UNKNOWN && rsp_data.right == '0
         && rsp_data.bottom == '0 && !rsp_data.found)
      else $error("empty color reported with a box");

   a_next_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.color_id == COLOR_RED
      |=> !rsp_valid || rsp_data.color_id == COLOR_YELLOW)
      else $error("yellow result does not follow red");

endmodule

bind color_blob_bounding_box_unit cbbox_checker u_cbbox_checker (.*);

// File: test/cbbox_tb_pkg.sv
// Testbench package for the color blob bounding box unit: a checker that tracks
// pixel position, per-color boxes and counts, and queues the per-frame results.
// Depends on cbbox_pkg.
package cbbox_tb_pkg;
   import cbbox_pkg::*;

   class color_box_checker;
      int unsigned max_w;
      int unsigned max_h;
      int unsigned image_width;
      int unsigned image_height;
      int unsigned min_area;
      int unsigned column;
      int unsigned row;
      int unsigned box_left[NUM_COLORS];
      int unsigned box_right[NUM_COLORS];
      int unsigned box_top[NUM_COLORS];
      int unsigned box_bottom[NUM_COLORS];
      int unsigned pixel_count[NUM_COLORS];
      rsp_type     pending_boxes[$];
      int          mismatches;
      int          pixels;
      int          checked;
      int          frames;

      function new(int unsigned max_w, int unsigned max_h);
         this.max_w   = max_w;
         this.max_h   = max_h;
         image_width  = RESET_IMAGE_WIDTH;
         image_height = RESET_IMAGE_HEIGHT;
         min_area     = RESET_MIN_AREA;
         column       = 0;
         row          = 0;
         mismatches   = 0;
         pixels       = 0;
         checked      = 0;
         frames       = 0;
         clear_boxes();
      endfunction

      function int unsigned fit(int unsigned v, int unsigned maxv);
         if (v == 0) begin
            return 1;
         end
         return (v > maxv) ? maxv : v;
      endfunction

      function void clear_boxes();
         for (int i = 0; i < NUM_COLORS; i++) begin
            box_left[i]    = fit(image_width, max_w);
            box_right[i]   = 0;
            box_top[i]     = fit(image_height, max_h);
            box_bottom[i]  = 0;
            pixel_count[i] = 0;
         end
      endfunction

      function void set_register(logic [1:0] idx, logic [31:0] val);
         case (idx)
            REG_IMAGE_WIDTH: begin
               image_width = val[12:0];
            end
            REG_IMAGE_HEIGHT: begin
               image_height = val[12:0];
            end
            REG_MIN_AREA: begin
               min_area = val[24:0];
            end
            default: begin
            end
         endcase
      endfunction

      function bit color_hit(logic [1:0] c, req_type px);
         int r;
         int g;
         int b;
         int d;
         r = px.red;
         g = px.green;
         b = px.blue;
         d = (r > g) ? r - g : g - r;
         case (c)
            COLOR_RED: begin
               return r > g + 50 && r > b + 50 && r > 120 && g < 80 && b < 80;
            end
            COLOR_YELLOW: begin
               return d < 30 && r > b + 40 && g > b + 40 && r > 120 && g > 120;
            end
            COLOR_BLUE: begin
               return b > r + 40 && b > g + 40 && b > 120 && r < 100 && g < 100;
            end
            default: begin
               return 1'b0;
            end
         endcase
      endfunction

      function void take_pixel(req_type px);
         int unsigned     w;
         int unsigned     h;
         bit              row_end;
         rsp_type         box;
         longint unsigned bw;
         longint unsigned bh;
         w = fit(image_width, max_w);
         h = fit(image_height, max_h);
         pixels++;
         for (int i = 0; i < NUM_COLORS; i++) begin
            if (color_hit(2'(i), px)) begin
               if (pixel_count[i] == 0) begin
                  box_left[i]   = column;
                  box_right[i]  = column;
                  box_top[i]    = row;
                  box_bottom[i] = row;
               end else begin
                  if (column < box_left[i]) box_left[i] = column;
                  if (column > box_right[i]) box_right[i] = column;
                  if (row < box_top[i]) box_top[i] = row;
                  if (row > box_bottom[i]) box_bottom[i] = row;
               end
               if (pixel_count[i] < COUNT_MAX) pixel_count[i]++;
            end
         end
         row_end = (column + 1 >= w);
         if (!(row_end && row + 1 >= h)) begin
            if (row_end) begin
               column = 0;
               row++;
            end else begin
               column++;
            end
            return;
         end
         for (int i = 0; i < NUM_COLORS; i++) begin
            box = '0;
            box.color_id = 2'(i);
            if (pixel_count[i] == 0) begin
               box.left  = 13'(w);
               box.top   = 13'(h);
               box.shape = SHAPE_UNKNOWN;
            end else begin
               box.left   = 13'(box_left[i]);
               box.right  = 12'(box_right[i]);
               box.top    = 13'(box_top[i]);
               box.bottom = 12'(box_bottom[i]);
               bw = longint'(box_right[i]) - box_left[i] + 1;
               bh = longint'(box_bottom[i]) - box_top[i] + 1;
               box.shape = (longint'(pixel_count[i]) * 20 > bw * bh * 17)
                           ? SHAPE_CUBE : SHAPE_BALL;
            end
            box.area  = 25'(pixel_count[i]);
            box.found = pixel_count[i] > min_area;
            box.last  = (i == NUM_COLORS - 1);
            pending_boxes.push_back(box);
         end
         frames++;
         column = 0;
         row    = 0;
         clear_boxes();
      endfunction

      function void compare_field(string name, logic [1:0] color, logic [31:0] want,
                                  logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: color %0d %s mismatch, expected %0d actual %0d",
                     $time, color, name, want, got);
         end
      endfunction

      function void check_box(rsp_type got);
         rsp_type want;
         if (pending_boxes.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual color %0d area %0d",
                     $time, got.color_id, got.area);
            return;
         end
         want = pending_boxes.pop_front();
         checked++;
         compare_field("color_id", want.color_id, want.color_id, got.color_id);
         compare_field("left", want.color_id, want.left, got.left);
         compare_field("right", want.color_id, want.right, got.right);
         compare_field("top", want.color_id, want.top, got.top);
         compare_field("bottom", want.color_id, want.bottom, got.bottom);
         compare_field("area", want.color_id, want.area, got.area);
         compare_field("found", want.color_id, want.found, got.found);
         compare_field("shape", want.color_id, want.shape, got.shape);
         compare_field("last", want.color_id, want.last, got.last);
      endfunction
   endclass

endpackage

// File: test/tb.sv
// Top-level testbench for color_blob_bounding_box_unit: directed and random
// pixel frames under varying sizes and handshake stalls.
// Depends on cbbox_pkg and cbbox_tb_pkg.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cbbox_pkg::*;
   import cbbox_tb_pkg::*;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   color_box_checker boxes;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles   = 0;
   int cycle_count   = 0;
   int reg_writes    = 0;

   color_blob_bounding_box_unit #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) boxes.take_pixel(req_data);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) boxes.check_box(rsp_data);
   end

   // receiver: long hold-off when requested, otherwise random stalls
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   function automatic req_type rgb(int r, int g, int b);
      req_type px;
      px.red   = 8'(r);
      px.green = 8'(g);
      px.blue  = 8'(b);
      return px;
   endfunction

   function automatic int threshold_value();
      case ($urandom_range(0, 13))
         0: return 0;
         1: return 29;
         2: return 30;
         3: return 40;
         4: return 41;
         5: return 50;
         6: return 51;
         7: return 79;
         8: return 80;
         9: return 99;
         10: return 100;
         11: return 120;
         12: return 121;
         default: return 255;
      endcase
   endfunction

   function automatic req_type random_pixel();
      int r;
      int g;
      int b;
      int lo;
      int hi;
      case ($urandom_range(0, 9))
         0, 1: begin
            r  = $urandom_range(121, 255);
            hi = (r - 51 > 79) ? 79 : r - 51;
            return rgb(r, $urandom_range(0, hi), $urandom_range(0, hi));
         end
         2, 3: begin
            r  = $urandom_range(121, 255);
            lo = (r - 29 < 121) ? 121 : r - 29;
            hi = (r + 29 > 255) ? 255 : r + 29;
            g  = $urandom_range(lo, hi);
            hi = ((r < g) ? r : g) - 41;
            return rgb(r, g, $urandom_range(0, hi));
         end
         4, 5: begin
            b  = $urandom_range(121, 255);
            hi = (b - 41 > 99) ? 99 : b - 41;
            return rgb($urandom_range(0, hi), $urandom_range(0, hi), b);
         end
         6: begin
            return rgb(threshold_value(), threshold_value(), threshold_value());
         end
         default: begin
            return req_type'(24'($urandom_range(0, 24'hFFFFFF)));
         end
      endcase
   endfunction

   task automatic send_pixel(input req_type px);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid, let all frame results drain, then let the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (boxes.pending_boxes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      boxes.set_register(idx, val);
      reg_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      int phase_items;
      int w;
      int h;
      int npx;
      logic [31:0] area_min;

      boxes       = new(MAX_WIDTH, MAX_HEIGHT);
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 3x2 frames: rule thresholds just inside and just outside
      write_register(REG_IMAGE_WIDTH, 3);
      write_register(REG_IMAGE_HEIGHT, 2);
      write_register(REG_MIN_AREA, 0);
      send_pixel(rgb(0, 0, 0));
      send_pixel(rgb(255, 255, 255));
      send_pixel(rgb(121, 70, 70));
      send_pixel(rgb(120, 0, 0));
      send_pixel(rgb(255, 255, 0));
      send_pixel(rgb(0, 0, 255));
      send_pixel(rgb(150, 121, 80));
      send_pixel(rgb(151, 121, 80));
      send_pixel(rgb(80, 80, 121));
      send_pixel(rgb(100, 80, 200));
      send_pixel(rgb(255, 79, 79));
      send_pixel(rgb(255, 80, 0));

      // single-pixel frame with no match, max min area
      wait_idle();
      write_register(REG_IMAGE_WIDTH, 1);
      write_register(REG_IMAGE_HEIGHT, 1);
      write_register(REG_MIN_AREA, 32'h1FF_FFFF);
      send_pixel(rgb(0, 0, 0));

      // zero sizes clamp to 1
      wait_idle();
      write_register(REG_IMAGE_WIDTH, 0);
      write_register(REG_IMAGE_HEIGHT, 0);
      write_register(REG_MIN_AREA, 0);
      send_pixel(rgb(255, 0, 0));

      // oversize width clamps; shrink mid-frame so the column counter wraps
      wait_idle();
      write_register(REG_IMAGE_WIDTH, 8191);
      write_register(REG_IMAGE_HEIGHT, 4096);
      write_register(REG_MIN_AREA, 16777216);
      send_pixel(rgb(0, 0, 200));
      send_pixel(rgb(10, 20, 255));
      send_pixel(rgb(0, 0, 0));
      send_pixel(rgb(200, 210, 0));
      wait_idle();
      write_register(REG_IMAGE_WIDTH, 2);
      write_register(REG_IMAGE_HEIGHT, 1);
      send_pixel(rgb(200, 0, 0));

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 24;
               recv_idle_pct = 61;
            end
            1: begin
               send_idle_pct = 61;
               recv_idle_pct = 24;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_items = 0;
         while (phase_items < 24) begin
            w = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
            h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
            case ($urandom_range(0, 5))
               0: area_min = 0;
               1: area_min = 16777216;
               2: area_min = 32'h1FF_FFFF;
               default: area_min = $urandom_range(0, 8);
            endcase
            wait_idle();
            write_register(REG_IMAGE_WIDTH, w);
            write_register(REG_IMAGE_HEIGHT, h);
            write_register(REG_MIN_AREA, area_min);
            // whole frames, sometimes with a partial frame left open
            npx = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) npx += $urandom_range(1, 3);
            repeat (npx) send_pixel(random_pixel());
            phase_items += npx;
         end
      end

      // receiver holds off while 1x1 frames keep coming, so the input backs up
      wait_idle();
      write_register(REG_IMAGE_WIDTH, 1);
      write_register(REG_IMAGE_HEIGHT, 1);
      hold_cycles = 150;
      repeat (16) send_pixel(random_pixel());

      recv_idle_pct = 0;
      wait_idle();
      $display("Checked %0d results from %0d frames over %0d pixels, %0d register writes",
               boxes.checked, boxes.frames, boxes.pixels, reg_writes);
      $display("Sizes from clamped 1x1 to clamped 4096 wide, mid-frame resize, stalls");
      if (boxes.mismatches == 0 && boxes.pending_boxes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/cbbox_pkg.sv
src/cbbox_tracker.sv
src/color_blob_bounding_box_unit.sv
src/cbbox_checker.sv
test/cbbox_tb_pkg.sv
test/tb.sv
